>>> sv/sbga_pkg.sv
`timescale 1ns / 1ps
// Shared widths and defaults for the strength-based greedy aggregation block.
// No dependencies; every other file imports this package.
package sbga_pkg;

  // Field widths
  localparam int COL_W   = 10;
  localparam int VAL_W   = 32;
  localparam int RATIO_W = 16;
  localparam int ID_W    = 10;

  // Threshold product: signed Q15.16 value times unsigned Q0.16 ratio
  localparam int THR_W   = VAL_W + RATIO_W + 1;

  // Reset value of the ratio register (0.25)
  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd16384;

  // Defaults for the top-level parameters
  localparam int MAX_ROWS_DEF        = 1024;
  localparam int MAX_ROW_ENTRIES_DEF = 32;

  // Matrix epoch tag kept with each aggregate store entry
  localparam int EPOCH_W = 4;

endpackage

>>> sv/sbga_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: entry input, row result output, ratio write.
// Depends on sbga_pkg for the field widths.

interface sbga_in_if import sbga_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    start_of_matrix;
  logic [COL_W-1:0]        column;
  logic signed [VAL_W-1:0] entry_value;
  logic                    end_of_row;

  modport source (output valid, start_of_matrix, column, entry_value, end_of_row,
                  input ready);
  modport sink   (input valid, start_of_matrix, column, entry_value, end_of_row,
                  output ready);
endinterface

interface sbga_out_if import sbga_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  row_index;
  logic [ID_W-1:0]  aggregate_id;
  logic             row_overflow;

  modport source (output valid, row_index, aggregate_id, row_overflow, input ready);
  modport sink   (input valid, row_index, aggregate_id, row_overflow, output ready);
endinterface

interface sbga_cfg_if import sbga_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RATIO_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> sv/strength_based_greedy_aggregation.sv
`timescale 1ns / 1ps
// Strength-based greedy aggregation: sparse matrix entries stream in on in_chan
// in row order (column, value, start_of_matrix, end_of_row). Each entry with
// end_of_row gives one transfer on out_chan: row index, aggregate id, overflow.
// cfg_chan writes the Q0.16 strength ratio; it is always ready. It must be
// written only while the block is idle; the block itself does not enforce this.
// Each entry is accepted, then written to the row buffer; start_of_matrix adds
// a start state between the two. At a row end the block makes one pass of the
// row buffer read port to find the diagonal, one multiply, a store lookup, then
// for each entry a claim pass through the shared strength compare and the
// aggregate store read/write port. Visited rows skip the claim.
// The aggregate store keeps a matrix epoch tag per row; every 15th matrix
// start, and after reset, a sweep over all MAX_ROWS rows rewrites the tags while
// in_chan is not ready.
// Reset: ratio returns to 0.25, counters clear, the sweep runs.
// A stalled receiver holds the result; the next entries are still accepted
// until the next row end, which waits for the output register to drain.
// Depends on sbga_pkg, sbga_if, sbga_ram, sbga_strength.
module strength_based_greedy_aggregation import sbga_pkg::*; #(
  parameter int MAX_ROWS        = MAX_ROWS_DEF,
  parameter int MAX_ROW_ENTRIES = MAX_ROW_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sbga_in_if.sink    in_chan,
  sbga_out_if.source out_chan,
  sbga_cfg_if.sink   cfg_chan
);

  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int CUR_W  = $clog2(MAX_ROWS + 1);
  localparam int RB_AW  = $clog2(MAX_ROW_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ROW_ENTRIES + 1);
  localparam int RB_DW  = COL_W + VAL_W;
  localparam int AM_DW  = EPOCH_W + ROW_AW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_BUF, S_DIAG, S_MUL, S_LOOK,
    S_CL_A, S_CL_B, S_CL_C, S_EMIT
  } state_t;

  // Control registers
  state_t               state_r, state_nxt;
  logic                 resume_r, resume_nxt;
  logic [EPOCH_W-1:0]   epoch_r, epoch_nxt;
  logic [ROW_AW-1:0]    sweep_r, sweep_nxt;
  logic [CNT_W-1:0]     row_cnt_r, row_cnt_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CUR_W-1:0]     cur_row_r, cur_row_nxt;
  logic [CUR_W-1:0]     next_agg_r, next_agg_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [RATIO_W-1:0]   ratio_r, ratio_nxt;

  // Payload registers
  logic [COL_W-1:0]     hold_col_r, hold_col_nxt;
  logic [VAL_W-1:0]     hold_val_r, hold_val_nxt;
  logic                 hold_eor_r, hold_eor_nxt;
  logic [VAL_W-1:0]     diag_r, diag_nxt;
  logic [ROW_AW-1:0]    agg_r, agg_nxt;
  logic [ROW_AW-1:0]    col_r, col_nxt;
  logic                 cand_r, cand_nxt;
  logic [ID_W-1:0]      res_row_r, res_row_nxt;
  logic [ID_W-1:0]      res_agg_r, res_agg_nxt;
  logic                 res_ovf_r, res_ovf_nxt;
  logic [ID_W-1:0]      out_row_r, out_row_nxt;
  logic [ID_W-1:0]      out_agg_r, out_agg_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  // Memory ports
  logic                 rb_we;
  logic [RB_AW-1:0]     rb_waddr, rb_raddr;
  logic [RB_DW-1:0]     rb_wdata, rb_rdata;
  logic                 am_we;
  logic [ROW_AW-1:0]    am_waddr, am_raddr;
  logic [AM_DW-1:0]     am_wdata, am_rdata;

  // Strength unit
  logic                 thr_load, abs_load, is_strong;

  // Widened views for width-independent compares and slicing
  logic [31:0]          cur_row_ext, rb_col_ext, look_agg_ext, next_agg_ext;
  logic [ROW_AW-1:0]    cur_row_addr;
  logic [EPOCH_W-1:0]   am_tag;
  logic                 in_xfer, room;

  assign cur_row_ext  = 32'(cur_row_r);
  assign rb_col_ext   = 32'(rb_rdata[RB_DW-1:VAL_W]);
  assign look_agg_ext = 32'(am_rdata[ROW_AW-1:0]);
  assign next_agg_ext = 32'(next_agg_r);
  assign cur_row_addr = cur_row_ext[ROW_AW-1:0];
  assign am_tag       = am_rdata[AM_DW-1:ROW_AW];
  assign in_xfer      = in_chan.valid & in_chan.ready;
  assign room         = (row_cnt_r < CNT_W'(MAX_ROW_ENTRIES));

  assign in_chan.ready         = (state_r == S_IDLE);
  assign cfg_chan.ready        = 1'b1;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.row_index    = out_row_r;
  assign out_chan.aggregate_id = out_agg_r;
  assign out_chan.row_overflow = out_ovf_r;

  sbga_ram #(.DEPTH(MAX_ROW_ENTRIES), .DW(RB_DW)) u_row_buf (
    .clk   (clk),
    .we    (rb_we),
    .waddr (rb_waddr),
    .wdata (rb_wdata),
    .raddr (rb_raddr),
    .rdata (rb_rdata)
  );

  sbga_ram #(.DEPTH(MAX_ROWS), .DW(AM_DW)) u_agg_mem (
    .clk   (clk),
    .we    (am_we),
    .waddr (am_waddr),
    .wdata (am_wdata),
    .raddr (am_raddr),
    .rdata (am_rdata)
  );

  sbga_strength u_strength (
    .clk       (clk),
    .thr_load  (thr_load),
    .diag      ($signed(diag_r)),
    .ratio     (ratio_r),
    .abs_load  (abs_load),
    .value     (rb_rdata[VAL_W-1:0]),
    .is_strong (is_strong)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    resume_nxt     = resume_r;
    epoch_nxt      = epoch_r;
    sweep_nxt      = sweep_r;
    row_cnt_nxt    = row_cnt_r;
    idx_nxt        = idx_r;
    cur_row_nxt    = cur_row_r;
    next_agg_nxt   = next_agg_r;
    ovf_nxt        = ovf_r;
    rd_vld_nxt     = rd_vld_r;
    out_valid_nxt  = out_valid_r & ~out_chan.ready;
    ratio_nxt      = cfg_chan.valid ? cfg_chan.data : ratio_r;
    hold_col_nxt   = hold_col_r;
    hold_val_nxt   = hold_val_r;
    hold_eor_nxt   = hold_eor_r;
    diag_nxt       = diag_r;
    agg_nxt        = agg_r;
    col_nxt        = col_r;
    cand_nxt       = cand_r;
    res_row_nxt    = res_row_r;
    res_agg_nxt    = res_agg_r;
    res_ovf_nxt    = res_ovf_r;
    out_row_nxt    = out_row_r;
    out_agg_nxt    = out_agg_r;
    out_ovf_nxt    = out_ovf_r;

    rb_we    = 1'b0;
    rb_waddr = row_cnt_r[RB_AW-1:0];
    rb_wdata = {hold_col_r, hold_val_r};
    rb_raddr = idx_r[RB_AW-1:0];
    am_we    = 1'b0;
    am_waddr = sweep_r;
    am_wdata = '0;
    am_raddr = cur_row_addr;
    thr_load = 1'b0;
    abs_load = 1'b0;

    unique case (state_r)
      // Tag sweep: every row reads as not visited afterwards
      S_CLEAR: begin
        am_we = 1'b1;
        if (sweep_r == ROW_AW'(MAX_ROWS - 1)) begin
          sweep_nxt  = '0;
          resume_nxt = 1'b0;
          state_nxt  = resume_r ? S_BUF : S_IDLE;
        end else begin
          sweep_nxt = sweep_r + ROW_AW'(1);
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          hold_col_nxt   = in_chan.column;
          hold_val_nxt   = in_chan.entry_value;
          hold_eor_nxt   = in_chan.end_of_row;
          state_nxt      = in_chan.start_of_matrix ? S_START : S_BUF;
        end
      end

      // New matrix: fresh epoch, counters back to zero
      S_START: begin
        row_cnt_nxt  = '0;
        cur_row_nxt  = '0;
        next_agg_nxt = '0;
        ovf_nxt      = 1'b0;
        if (epoch_r == '1) begin
          epoch_nxt  = EPOCH_W'(1);
          resume_nxt = 1'b1;
          state_nxt  = S_CLEAR;
        end else begin
          epoch_nxt = epoch_r + EPOCH_W'(1);
          state_nxt = S_BUF;
        end
      end

      // Buffer the entry or note the overflow
      S_BUF: begin
        if (room) begin
          rb_we       = 1'b1;
          row_cnt_nxt = row_cnt_r + CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        if (!hold_eor_r) begin
          state_nxt = S_IDLE;
        end else if (cur_row_r >= CUR_W'(MAX_ROWS)) begin
          res_row_nxt = cur_row_ext[ID_W-1:0];
          res_agg_nxt = '0;
          res_ovf_nxt = 1'b1;
          row_cnt_nxt = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = S_EMIT;
        end else begin
          idx_nxt    = '0;
          rd_vld_nxt = 1'b0;
          diag_nxt   = '0;
          state_nxt  = S_DIAG;
        end
      end

      // Diagonal scan, one buffer read per cycle; the last match wins
      S_DIAG: begin
        rd_vld_nxt = 1'b0;
        if (idx_r < row_cnt_r) begin
          rd_vld_nxt = 1'b1;
          idx_nxt    = idx_r + CNT_W'(1);
        end
        if (rd_vld_r && (rb_col_ext == cur_row_ext)) begin
          diag_nxt = rb_rdata[VAL_W-1:0];
        end
        if ((idx_r == row_cnt_r) && !rd_vld_r) begin
          state_nxt = S_MUL;
        end
      end

      // Threshold multiply; store read of the current row in flight
      S_MUL: begin
        thr_load  = 1'b1;
        state_nxt = S_LOOK;
      end

      S_LOOK: begin
        if (am_tag == epoch_r) begin
          res_agg_nxt = look_agg_ext[ID_W-1:0];
          res_row_nxt = cur_row_ext[ID_W-1:0];
          res_ovf_nxt = ovf_r;
          cur_row_nxt = cur_row_r + CUR_W'(1);
          row_cnt_nxt = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = S_EMIT;
        end else begin
          // Open a new aggregate for this row
          am_we        = 1'b1;
          am_waddr     = cur_row_addr;
          am_wdata     = {epoch_r, next_agg_r[ROW_AW-1:0]};
          agg_nxt      = next_agg_r[ROW_AW-1:0];
          res_agg_nxt  = next_agg_ext[ID_W-1:0];
          next_agg_nxt = next_agg_r + CUR_W'(1);
          idx_nxt      = '0;
          state_nxt    = S_CL_A;
        end
      end

      // Claim pass: read entry
      S_CL_A: begin
        if (idx_r == row_cnt_r) begin
          res_row_nxt = cur_row_ext[ID_W-1:0];
          res_ovf_nxt = ovf_r;
          cur_row_nxt = cur_row_r + CUR_W'(1);
          row_cnt_nxt = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = S_EMIT;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_CL_B;
        end
      end

      // Claim pass: magnitude into the strength unit, neighbour store read
      S_CL_B: begin
        abs_load  = 1'b1;
        am_raddr  = rb_col_ext[ROW_AW-1:0];
        col_nxt   = rb_col_ext[ROW_AW-1:0];
        cand_nxt  = (rb_col_ext != cur_row_ext) && (rb_col_ext < 32'(MAX_ROWS));
        state_nxt = S_CL_C;
      end

      // Claim pass: take a strong, unvisited neighbour
      S_CL_C: begin
        if (cand_r && is_strong && (am_tag != epoch_r)) begin
          am_we    = 1'b1;
          am_waddr = col_r;
          am_wdata = {epoch_r, agg_r};
        end
        state_nxt = S_CL_A;
      end

      // Hand the result to the output register once it is free
      S_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = res_row_r;
          out_agg_nxt   = res_agg_r;
          out_ovf_nxt   = res_ovf_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      resume_r    <= 1'b0;
      epoch_r     <= EPOCH_W'(1);
      sweep_r     <= '0;
      row_cnt_r   <= '0;
      idx_r       <= '0;
      cur_row_r   <= '0;
      next_agg_r  <= '0;
      ovf_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      ratio_r     <= RATIO_RESET;
    end else begin
      state_r     <= state_nxt;
      resume_r    <= resume_nxt;
      epoch_r     <= epoch_nxt;
      sweep_r     <= sweep_nxt;
      row_cnt_r   <= row_cnt_nxt;
      idx_r       <= idx_nxt;
      cur_row_r   <= cur_row_nxt;
      next_agg_r  <= next_agg_nxt;
      ovf_r       <= ovf_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      ratio_r     <= ratio_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    hold_col_r   <= hold_col_nxt;
    hold_val_r   <= hold_val_nxt;
    hold_eor_r   <= hold_eor_nxt;
    diag_r       <= diag_nxt;
    agg_r        <= agg_nxt;
    col_r        <= col_nxt;
    cand_r       <= cand_nxt;
    res_row_r    <= res_row_nxt;
    res_agg_r    <= res_agg_nxt;
    res_ovf_r    <= res_ovf_nxt;
    out_row_r    <= out_row_nxt;
    out_agg_r    <= out_agg_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

endmodule

>>> sv/sbga_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port with registered data.
// Used for the row entry buffer and the aggregate store. Imports sbga_pkg.
module sbga_ram import sbga_pkg::*; #(
  parameter int DEPTH = MAX_ROW_ENTRIES_DEF,
  parameter int DW    = COL_W + VAL_W,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write first in code order, read returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sbga_strength.sv
`timescale 1ns / 1ps
// Strength test unit: registers threshold = diag * ratio and |value|, then
// compares |value| * 2^16 against the threshold. Imports sbga_pkg.
module sbga_strength import sbga_pkg::*; (
  input  logic                    clk,
  input  logic                    thr_load,
  input  logic signed [VAL_W-1:0] diag,
  input  logic [RATIO_W-1:0]      ratio,
  input  logic                    abs_load,
  input  logic [VAL_W-1:0]        value,
  output logic                    is_strong
);

  logic signed [THR_W-1:0] thr_r;
  logic [VAL_W-1:0]        abs_r;
  logic [VAL_W-1:0]        abs_nxt;

  // Magnitude of a two's complement value; the most negative one fits unsigned
  assign abs_nxt = value[VAL_W-1] ? (~value + VAL_W'(1)) : value;

  always_ff @(posedge clk) begin
    if (thr_load) begin
      thr_r <= THR_W'(diag) * THR_W'($signed({1'b0, ratio}));
    end
    if (abs_load) begin
      abs_r <= abs_nxt;
    end
  end

  // Negative threshold: everything is strong
  assign is_strong = thr_r[THR_W-1] |
                     ({1'b0, abs_r, RATIO_W'(0)} > $unsigned(thr_r));

endmodule
